// ===== rtl/tbfe_pkg.sv =====
package tbfe_pkg;

  // Input item codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Coefficient table select
  localparam logic [1:0] BAND_LOW  = 2'd0;
  localparam logic [1:0] BAND_HIGH = 2'd1;
  localparam logic [1:0] BAND_MID  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_LOW_EN  = 2'd0;
  localparam logic [1:0] REG_HIGH_EN = 2'd1;
  localparam logic [1:0] REG_MID_EN  = 2'd2;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int SUM_W    = 34;
  localparam int FRAC_W   = 15;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write zeros at the sweep address, advance
    logic start;   // store new sample, rewind tap counter, clear accumulator
    logic load;    // write one coefficient
    logic issue;   // read one tap, advance
    logic finish;  // scale, saturate, load output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tap_last;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/three_band_fir_equalizer_unit.sv =====
// Three-band FIR equaliser: low-pass, high-pass and band-pass filters of
// NUM_TAPS taps share one circular delay line of signed 16-bit samples.
// A load word (in_op = 1) writes one Q1.15 coefficient into the table picked
// by in_band_select; an unused band code or a tap index of NUM_TAPS or more
// is dropped without effect. A sample word (in_op = 0) produces one
// output word: the sum over all taps and all enabled bands of coefficient
// times delayed sample, scaled by 2^-15 with truncation toward zero and
// saturated to 16 bits. The block takes no new word until a sample word is
// done: one multiply-accumulate per tap through the single read port of each
// memory, a drain of the MAC pipeline, then a step to scale and register the
// result. A finished word waits in the output register while the next word
// is taken; a second finished word holds the block in the scale step until
// the first has been taken. After reset the block sweeps all four memories
// to zero, one address per cycle, during which in_ready stays low;
// configuration writes are taken at any time.
module three_band_fir_equalizer_unit
  import tbfe_pkg::*;
#(
  parameter int NUM_TAPS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [15:0] in_audio_in,
  input  logic [1:0]         in_band_select,
  input  logic [9:0]         in_tap_index,
  input  logic signed [15:0] in_coef_value,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_audio_out,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Band enables are plain registers: accept every configuration word.
  assign cfg_ready = 1'b1;

  tbfe_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid,
    .in_op,
    .status,
    .in_ready,
    .cmd
  );

  tbfe_dp #(.NUM_TAPS(NUM_TAPS)) u_dp (
    .clk,
    .rst_n,
    .cmd,
    .status,
    .in_audio_in,
    .in_band_select,
    .in_tap_index,
    .in_coef_value,
    .cfg_wr(cfg_valid && cfg_ready),
    .cfg_index,
    .cfg_data,
    .out_ready,
    .out_valid,
    .out_audio_out
  );

  // Commands to the datapath never overlap.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.start, cmd.load, cmd.issue, cmd.finish}))
    else $error("overlapping datapath commands");

  // A new word is only taken once the MAC pipeline has drained.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !status.pipe_busy)
    else $error("input taken with MAC pipeline busy");

  // An output word only appears after a scale-and-saturate step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("output word without finish");

  // The sweep after reset keeps the input channel closed.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !in_ready)
    else $error("input open during clearing sweep");

endmodule

// ===== rtl/tbfe_ram.sv =====
module tbfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tbfe_ctrl.sv =====
module tbfe_ctrl
  import tbfe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_op,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.tap_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_op == OP_SAMPLE) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (status.tap_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid && in_op == OP_SAMPLE;
        cmd.load  = in_valid && in_op == OP_LOAD;
      end
      ST_RUN:    cmd.issue  = 1'b1;
      ST_DRAIN:  cmd        = '0;
      ST_FINISH: cmd.finish = status.out_free;
      default:   cmd        = '0;
    endcase
  end

endmodule

// ===== rtl/tbfe_dp.sv =====
module tbfe_dp
  import tbfe_pkg::*;
#(
  parameter int NUM_TAPS = 1024,
  localparam int AW = $clog2(NUM_TAPS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic signed [SAMPLE_W-1:0] in_audio_in,
  input  logic [1:0]                 in_band_select,
  input  logic [9:0]                 in_tap_index,
  input  logic signed [SAMPLE_W-1:0] in_coef_value,
  input  logic                       cfg_wr,
  input  logic [1:0]                 cfg_index,
  input  logic                       cfg_data,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_audio_out
);

  localparam int ACC_W = SUM_W + $clog2(NUM_TAPS);
  localparam int Q_W   = ACC_W - FRAC_W;
  localparam int CMP_W = ((AW > 10) ? AW : 10) + 2;
  localparam logic [AW-1:0] LAST_TAP = AW'(NUM_TAPS - 1);
  localparam logic [ACC_W-1:0] RND = ACC_W'((2 ** FRAC_W) - 1);

  logic [AW-1:0] tap_cnt_r, tap_cnt_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic          v1_r, v2_r, v3_r;
  logic          low_en_r, high_en_r, mid_en_r;
  logic          out_valid_r;
  logic signed [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic signed [PROD_W-1:0]   prod_lo_r, prod_hi_r, prod_md_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic                tap_ok;
  logic                we_lo, we_hi, we_md, we_dl;
  logic [AW-1:0]       coef_waddr, dl_waddr;
  logic [SAMPLE_W-1:0] coef_wdata, dl_wdata;
  logic [SAMPLE_W-1:0] rd_lo, rd_hi, rd_md, rd_dl;
  logic [ACC_W-1:0]    biased;
  logic [Q_W-1:0]      q;

  // Memory write side
  assign tap_ok     = CMP_W'(in_tap_index) < CMP_W'(NUM_TAPS);
  assign coef_waddr = cmd.clear ? tap_cnt_r : AW'(in_tap_index);
  assign coef_wdata = cmd.clear ? '0 : in_coef_value;
  assign we_lo = cmd.clear || (cmd.load && tap_ok && in_band_select == BAND_LOW);
  assign we_hi = cmd.clear || (cmd.load && tap_ok && in_band_select == BAND_HIGH);
  assign we_md = cmd.clear || (cmd.load && tap_ok && in_band_select == BAND_MID);
  assign we_dl    = cmd.clear || cmd.start;
  assign dl_waddr = cmd.clear ? tap_cnt_r : wp_r;
  assign dl_wdata = cmd.clear ? '0 : in_audio_in;

  tbfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_TAPS)) u_ram_lo (
    .clk, .we(we_lo), .waddr(coef_waddr), .wdata(coef_wdata),
    .raddr(tap_cnt_r), .rdata(rd_lo)
  );
  tbfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_TAPS)) u_ram_hi (
    .clk, .we(we_hi), .waddr(coef_waddr), .wdata(coef_wdata),
    .raddr(tap_cnt_r), .rdata(rd_hi)
  );
  tbfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_TAPS)) u_ram_md (
    .clk, .we(we_md), .waddr(coef_waddr), .wdata(coef_wdata),
    .raddr(tap_cnt_r), .rdata(rd_md)
  );
  tbfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_TAPS)) u_ram_dl (
    .clk, .we(we_dl), .waddr(dl_waddr), .wdata(dl_wdata),
    .raddr(rd_ptr_r), .rdata(rd_dl)
  );

  // Counters and pointers
  always_comb begin
    tap_cnt_nxt = tap_cnt_r;
    rd_ptr_nxt  = rd_ptr_r;
    wp_nxt      = wp_r;
    if (cmd.start) begin
      tap_cnt_nxt = '0;
      rd_ptr_nxt  = wp_r;
    end else if (cmd.clear || cmd.issue) begin
      tap_cnt_nxt = (tap_cnt_r == LAST_TAP) ? '0 : tap_cnt_r + AW'(1);
      rd_ptr_nxt  = (rd_ptr_r == '0) ? LAST_TAP : rd_ptr_r - AW'(1);
    end
    if (cmd.finish) begin
      wp_nxt = (wp_r == LAST_TAP) ? '0 : wp_r + AW'(1);
    end
  end

  // Scale by 2^-15 truncating toward zero, then saturate
  assign biased = acc_r[ACC_W-1] ? acc_r + RND : acc_r;
  assign q      = biased[ACC_W-1:FRAC_W];

  always_comb begin
    if (&q[Q_W-1:SAMPLE_W-1] || ~|q[Q_W-1:SAMPLE_W-1]) begin
      out_data_nxt = q[SAMPLE_W-1:0];
    end else if (q[Q_W-1]) begin
      out_data_nxt = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      out_data_nxt = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_cnt_r   <= '0;
      rd_ptr_r    <= '0;
      wp_r        <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      low_en_r    <= 1'b0;
      high_en_r   <= 1'b1;
      mid_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tap_cnt_r <= tap_cnt_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      wp_r      <= wp_nxt;
      v1_r      <= cmd.issue;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      if (cfg_wr) begin
        case (cfg_index)
          REG_LOW_EN:  low_en_r  <= cfg_data;
          REG_HIGH_EN: high_en_r <= cfg_data;
          REG_MID_EN:  mid_en_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // MAC pipeline: read, multiply, band sum, accumulate
  always_ff @(posedge clk) begin
    prod_lo_r <= low_en_r  ? $signed(rd_lo) * $signed(rd_dl) : $signed(PROD_W'(0));
    prod_hi_r <= high_en_r ? $signed(rd_hi) * $signed(rd_dl) : $signed(PROD_W'(0));
    prod_md_r <= mid_en_r  ? $signed(rd_md) * $signed(rd_dl) : $signed(PROD_W'(0));
    sum_r <= {{(SUM_W-PROD_W){prod_lo_r[PROD_W-1]}}, prod_lo_r}
           + {{(SUM_W-PROD_W){prod_hi_r[PROD_W-1]}}, prod_hi_r}
           + {{(SUM_W-PROD_W){prod_md_r[PROD_W-1]}}, prod_md_r};
    if (cmd.start) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + {{(ACC_W-SUM_W){sum_r[SUM_W-1]}}, sum_r};
    end
    if (cmd.finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign status.tap_last  = tap_cnt_r == LAST_TAP;
  assign status.pipe_busy = v1_r || v2_r || v3_r;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_audio_out = out_data_r;

endmodule
